// ===== src/psi_pat_pmt_section_parser_top_macros.svh =====
// Assertion macros for the PSI section parser.
// Included by the top level; clock and reset are clk_i and rst_ni there.
`ifndef PSI_PAT_PMT_SECTION_PARSER_TOP_MACROS_SVH
`define PSI_PAT_PMT_SECTION_PARSER_TOP_MACROS_SVH
`ifndef SYNTH
`define PPSP_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("%m: check failed");
`define PPSP_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("%m: check failed");
`else
`define PPSP_ASSERT(lbl, prop)
`define PPSP_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

// ===== src/ppsp_pkg.sv =====
// Types and constants shared by the PSI section parser modules.
// No dependencies.
`timescale 1ns / 1ps
package ppsp_pkg;

  localparam logic [7:0] ST_VIDEO_MPEG2 = 8'h02;
  localparam logic [7:0] ST_AUDIO_MPEG1 = 8'h03;
  localparam logic [7:0] ST_AUDIO_MPEG2 = 8'h04;
  localparam logic [7:0] TAG_LANGUAGE   = 8'h0a;
  localparam logic [7:0] TAG_CAROUSEL   = 8'h13;
  localparam logic [7:0] TAG_STREAM_ID  = 8'h52;
  localparam logic [7:0] COUNT_MAX      = 8'hff;

  typedef enum logic [1:0] {
    REG_SERVICE_NUMBER  = 2'd0,
    REG_CAROUSEL_FILTER = 2'd1,
    REG_CAROUSEL_ANY    = 2'd2
  } reg_index_e;

  typedef enum logic [2:0] {
    EV_PMT_PID     = 3'd0,
    EV_VIDEO       = 3'd1,
    EV_AUDIO       = 3'd2,
    EV_CAROUSEL    = 3'd3,
    EV_COMPONENT   = 3'd4,
    EV_PAT_MISS    = 3'd5,
    EV_PMT_END     = 3'd6
  } event_kind_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       section_start;
    logic       table_kind;
  } in_item_t;

  typedef struct packed {
    event_kind_e event_kind;
    logic [12:0] stream_pid;
    logic [7:0]  stream_kind;
    logic [31:0] event_value;
    logic        error_flag;
  } out_item_t;

  typedef struct packed {
    logic [15:0] service_number;
    logic [31:0] carousel_filter;
    logic        carousel_match_any;
  } cfg_t;

  typedef struct packed {
    logic      valid;
    out_item_t item;
  } event_t;

endpackage

// ===== src/ppsp_parser.sv =====
// Section byte parser: parse state and the per-byte event decision.
// Depends on ppsp_pkg.
`timescale 1ns / 1ps
module ppsp_parser
  import ppsp_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     accept_i,
  input  in_item_t item_i,
  input  cfg_t     cfg_i,
  output event_t   ev_o
);

  typedef enum logic [3:0] {
    PH_IDLE, PH_PAT_HDR, PH_PAT_ENTRY, PH_PMT_HDR, PH_PMT_INFO,
    PH_ES_TYPE, PH_ES_PIDH, PH_ES_PIDL, PH_ES_LENH, PH_ES_LENL,
    PH_D_TAG, PH_D_LEN, PH_D_BODY, PH_DONE
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [12:0] pos_q, pos_d;
  logic [12:0] size_q, size_d;
  logic [11:0] fc_q, fc_d;
  logic [11:0] lr_q, lr_d;
  logic [7:0]  skind_q, skind_d;
  logic [12:0] pid_q, pid_d;
  logic [7:0]  tag_q, tag_d;
  logic [31:0] aw_q, aw_d;
  logic        found_q, found_d;
  logic [7:0]  ccount_q, ccount_d;
  logic [2:0]  pidx_q, pidx_d;

  logic [7:0]  b;
  logic [31:0] aw_shift;
  logic [11:0] lr_dec;
  logic [11:0] dlen;
  logic [11:0] fc_dec;
  logic [12:0] pid_full;
  logic [13:0] pos_ext;
  logic        in_body;
  logic        at_end;

  assign b        = item_i.data_byte;
  assign aw_shift = {aw_q[23:0], b};
  assign lr_dec   = lr_q - 12'd1;
  assign dlen     = ({4'd0, b} < lr_dec) ? {4'd0, b} : lr_dec;
  assign fc_dec   = fc_q - 12'd1;
  assign pid_full = pid_q | {5'd0, b};
  assign pos_ext  = {1'b0, pos_q};
  assign in_body  = (pos_ext + 14'd4) < {1'b0, size_q};
  assign at_end   = (pos_q >= 13'd2) && ((pos_ext + 14'd1) == {1'b0, size_d});

  always_comb begin
    phase_d  = phase_q;
    pos_d    = pos_q;
    size_d   = size_q;
    fc_d     = fc_q;
    lr_d     = lr_q;
    skind_d  = skind_q;
    pid_d    = pid_q;
    tag_d    = tag_q;
    aw_d     = aw_q;
    found_d  = found_q;
    ccount_d = ccount_q;
    pidx_d   = pidx_q;
    ev_o     = '0;
    if (accept_i) begin
      if (item_i.section_start) begin
        pos_d    = 13'd1;
        size_d   = '0;
        fc_d     = '0;
        lr_d     = '0;
        skind_d  = '0;
        pid_d    = '0;
        tag_d    = '0;
        aw_d     = '0;
        found_d  = 1'b0;
        ccount_d = '0;
        pidx_d   = '0;
        phase_d  = item_i.table_kind ? PH_PMT_HDR : PH_PAT_HDR;
      end else if (phase_q != PH_IDLE && phase_q != PH_DONE) begin
        pos_d = pos_q + 13'd1;
        if (pos_q == 13'd1) begin
          size_d = {1'b0, b[3:0], 8'h00};
        end else if (pos_q == 13'd2) begin
          size_d = size_q + {5'd0, b} + 13'd3;
        end else if (phase_q == PH_PAT_HDR) begin
          if (pos_q == 13'd7) begin
            phase_d = PH_PAT_ENTRY;
            fc_d    = '0;
            aw_d    = '0;
          end
        end else if (phase_q == PH_PMT_HDR) begin
          if (pos_q == 13'd10) begin
            lr_d = {b[3:0], 8'h00};
          end else if (pos_q == 13'd11) begin
            lr_d    = lr_q | {4'd0, b};
            phase_d = ((lr_q | {4'd0, b}) != '0) ? PH_PMT_INFO : PH_ES_TYPE;
          end
        end else if (in_body) begin
          case (phase_q)
            PH_PAT_ENTRY: begin
              aw_d = aw_shift;
              if (fc_q[1:0] == 2'd3 && !found_q &&
                  aw_shift[31:16] == cfg_i.service_number) begin
                found_d                = 1'b1;
                ev_o.valid             = 1'b1;
                ev_o.item.event_kind   = EV_PMT_PID;
                ev_o.item.stream_pid   = aw_shift[12:0];
              end
              fc_d = {10'd0, fc_q[1:0] + 2'd1};
            end
            PH_PMT_INFO: begin
              lr_d = lr_dec;
              if (lr_dec == '0) begin
                phase_d = PH_ES_TYPE;
              end
            end
            PH_ES_TYPE: begin
              skind_d = b;
              phase_d = PH_ES_PIDH;
            end
            PH_ES_PIDH: begin
              pid_d   = {b[4:0], 8'h00};
              phase_d = PH_ES_PIDL;
            end
            PH_ES_PIDL: begin
              pid_d = pid_full;
              if (skind_q == ST_VIDEO_MPEG2) begin
                ev_o.valid            = 1'b1;
                ev_o.item.event_kind  = EV_VIDEO;
                ev_o.item.stream_pid  = pid_full;
                ev_o.item.stream_kind = skind_q;
              end
              phase_d = PH_ES_LENH;
            end
            PH_ES_LENH: begin
              lr_d    = {b[3:0], 8'h00};
              phase_d = PH_ES_LENL;
            end
            PH_ES_LENL: begin
              lr_d    = lr_q | {4'd0, b};
              phase_d = ((lr_q | {4'd0, b}) != '0) ? PH_D_TAG : PH_ES_TYPE;
            end
            PH_D_TAG: begin
              tag_d   = b;
              lr_d    = lr_dec;
              phase_d = (lr_dec != '0) ? PH_D_LEN : PH_ES_TYPE;
            end
            PH_D_LEN: begin
              lr_d   = lr_dec - dlen;
              fc_d   = dlen;
              pidx_d = '0;
              aw_d   = '0;
              if (dlen == '0) begin
                phase_d = ((lr_dec - dlen) != '0) ? PH_D_TAG : PH_ES_TYPE;
              end else begin
                phase_d = PH_D_BODY;
              end
            end
            PH_D_BODY: begin
              aw_d = aw_shift;
              if (pidx_q == 3'd0 && tag_q == TAG_STREAM_ID) begin
                ev_o.valid             = 1'b1;
                ev_o.item.event_kind   = EV_COMPONENT;
                ev_o.item.stream_pid   = pid_q;
                ev_o.item.stream_kind  = skind_q;
                ev_o.item.event_value  = {24'd0, b};
              end else if (pidx_q == 3'd3 && tag_q == TAG_CAROUSEL) begin
                if (cfg_i.carousel_match_any || aw_shift == cfg_i.carousel_filter) begin
                  if (ccount_q != COUNT_MAX) begin
                    ccount_d = ccount_q + 8'd1;
                  end
                  ev_o.valid            = 1'b1;
                  ev_o.item.event_kind  = EV_CAROUSEL;
                  ev_o.item.stream_pid  = pid_q;
                  ev_o.item.stream_kind = skind_q;
                  ev_o.item.event_value = aw_shift;
                end
              end else if (pidx_q == 3'd3 && tag_q == TAG_LANGUAGE &&
                           (skind_q == ST_AUDIO_MPEG1 || skind_q == ST_AUDIO_MPEG2) &&
                           b == 8'h00) begin
                ev_o.valid            = 1'b1;
                ev_o.item.event_kind  = EV_AUDIO;
                ev_o.item.stream_pid  = pid_q;
                ev_o.item.stream_kind = skind_q;
              end
              if (pidx_q < 3'd4) begin
                pidx_d = pidx_q + 3'd1;
              end
              fc_d = fc_dec;
              if (fc_dec == '0) begin
                phase_d = (lr_q != '0) ? PH_D_TAG : PH_ES_TYPE;
              end
            end
            default: begin
            end
          endcase
        end
        if (at_end) begin
          ev_o = '0;
          if (phase_d == PH_PAT_HDR || phase_d == PH_PAT_ENTRY) begin
            ev_o.valid           = !found_d;
            ev_o.item.event_kind = EV_PAT_MISS;
          end else begin
            ev_o.valid            = 1'b1;
            ev_o.item.event_kind  = EV_PMT_END;
            ev_o.item.event_value = {24'd0, ccount_d};
            ev_o.item.error_flag  = (ccount_d == '0);
          end
          phase_d = PH_DONE;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_IDLE;
      pos_q    <= '0;
      size_q   <= '0;
      fc_q     <= '0;
      lr_q     <= '0;
      skind_q  <= '0;
      pid_q    <= '0;
      tag_q    <= '0;
      aw_q     <= '0;
      found_q  <= 1'b0;
      ccount_q <= '0;
      pidx_q   <= '0;
    end else begin
      phase_q  <= phase_d;
      pos_q    <= pos_d;
      size_q   <= size_d;
      fc_q     <= fc_d;
      lr_q     <= lr_d;
      skind_q  <= skind_d;
      pid_q    <= pid_d;
      tag_q    <= tag_d;
      aw_q     <= aw_d;
      found_q  <= found_d;
      ccount_q <= ccount_d;
      pidx_q   <= pidx_d;
    end
  end

endmodule

// ===== src/psi_pat_pmt_section_parser_top.sv =====
// PAT/PMT section parser: takes one section byte per cycle unless stalled
// and reports at most one event per byte, decided combinationally and
// loaded into the output register at the edge that accepts the byte.
// Input stall rises only while the output register holds an event that
// the downstream side stalls. The user must write the APB registers at
// byte addresses 0, 4 and 8 only while the block is idle; it is not enforced.
// Depends on ppsp_pkg, ppsp_parser and the assertion macro header.
`timescale 1ns / 1ps
`include "psi_pat_pmt_section_parser_top_macros.svh"
module psi_pat_pmt_section_parser_top
  import ppsp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  in_item_t    in_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_item_t   out_data_o
);

  cfg_t       cfg_q;
  reg_index_e reg_idx;
  logic       cfg_wr;
  logic       in_accept;
  event_t     ev;
  logic       out_valid_q;
  out_item_t  out_data_q;
  logic       out_err;
  logic       out_pmt_none;

  assign pready  = 1'b1;
  assign reg_idx = reg_index_e'(paddr[3:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    case (reg_idx)
      REG_SERVICE_NUMBER:  prdata = {16'd0, cfg_q.service_number};
      REG_CAROUSEL_FILTER: prdata = cfg_q.carousel_filter;
      REG_CAROUSEL_ANY:    prdata = {31'd0, cfg_q.carousel_match_any};
      default:             prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.service_number     <= '0;
      cfg_q.carousel_filter    <= '0;
      cfg_q.carousel_match_any <= 1'b1;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_SERVICE_NUMBER:  cfg_q.service_number     <= pwdata[15:0];
        REG_CAROUSEL_FILTER: cfg_q.carousel_filter    <= pwdata;
        REG_CAROUSEL_ANY:    cfg_q.carousel_match_any <= pwdata[0];
        default: begin
        end
      endcase
    end
  end

  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_accept  = in_valid_i && !in_stall_o;

  ppsp_parser u_parser (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (in_accept),
    .item_i   (in_data_i),
    .cfg_i    (cfg_q),
    .ev_o     (ev)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ev.valid) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ev.valid) begin
      out_data_q <= ev.item;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  assign out_err      = out_valid_o && out_data_o.error_flag;
  assign out_pmt_none = (out_data_o.event_kind == EV_PMT_END) &&
                        (out_data_o.event_value == 32'd0);

  `PPSP_ASSERT_ALWAYS(a_stall_needs_result, in_stall_o |-> out_valid_o)
  `PPSP_ASSERT(a_event_only_on_accept, ev.valid |-> in_accept)
  `PPSP_ASSERT(a_error_only_at_pmt_end, out_err |-> out_pmt_none)
  `PPSP_ASSERT(a_event_loads_output, ev.valid |=> (out_valid_o && out_data_o == $past(ev.item)))

endmodule
